@@ design/sel_pkg.sv @@
// Package for the shared/exclusive lock table: status codes, operation bits and
// control types. It has no dependencies.
`default_nettype none
package sel_pkg;
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_BADF  = 3'd1;
    localparam logic [2:0] ST_INVAL = 3'd2;
    localparam logic [2:0] ST_AGAIN = 3'd3;
    localparam logic [2:0] ST_FULL  = 3'd4;

    localparam logic [3:0] OP_SHARED = 4'd1;
    localparam logic [3:0] OP_EXCL   = 4'd2;
    localparam logic [3:0] OP_NONBLK = 4'd4;
    localparam logic [3:0] OP_UNLOCK = 4'd8;

    localparam logic FUNC_LOCK    = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    // One-hot sequencer states.
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_FIND  = 10'b0000000010,  // scan for a matching key
        S_FREE  = 10'b0000000100,  // scan for a free entry
        S_ENTRY = 10'b0000001000,  // entry header read back
        S_LIST  = 10'b0000010000,  // walk the shared list
        S_SHIFT = 10'b0000100000,  // close the gap left by a removed holder
        S_APPLY = 10'b0001000000,  // decide and write the header
        S_REL   = 10'b0010000000,  // release sweep over all entries
        S_RELW  = 10'b0100000000,  // shift the list and write the header in the sweep
        S_DONE  = 10'b1000000000
    } t_state;
endpackage
`default_nettype wire

@@ design/sel_if.sv @@
// Valid/ready channel interfaces for the lock table: request, result and
// configuration words. Depends on nothing.
`default_nettype none
interface sel_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [15:0] owner_id;
    logic [31:0] file_key;
    logic [3:0]  operation;
    modport source (output valid, func, owner_id, file_key, operation, input ready);
    modport sink   (input valid, func, owner_id, file_key, operation, output ready);
endinterface

interface sel_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    modport source (output valid, status, input ready);
    modport sink   (input valid, status, output ready);
endinterface

interface sel_cfg_if;
    logic valid;
    logic ready;
    logic tables_ready;
    modport source (output valid, tables_ready, input ready);
    modport sink   (input valid, tables_ready, output ready);
endinterface
`default_nettype wire

@@ design/shared_exclusive_lock_table.sv @@
// Shared/exclusive whole-file lock table.
// Request channel i_req carries func, owner_id, file_key and operation; the
// result channel o_rsp carries one status word per request. i_cfg writes the
// single tables_ready bit (reset value 1); it is taken only in the idle state
// and holds off a request offered in the same cycle.
// One request is worked at a time; i_req.ready is high only in the idle state.
// Run time is set by sequential scans over the entry memory, one entry per
// cycle through a registered read:
//   key lookup over all entries, then on a miss a free search over all entries;
//   shared list walk over the holders of the entry;
//   release/unlock: a sweep over every entry, walking and shifting the list of
//   each used one (a removal shifts the tail one slot per S_RELW/S_SHIFT pair).
// A request rejected at once (bad descriptor, invalid, no key, release while
// not ready) goes straight from idle to S_DONE; a lock runs S_FIND, S_FREE on a
// miss, S_ENTRY, S_LIST and S_APPLY; a release or unlock runs the S_REL sweep.
// The result becomes valid in the same cycle as the next request can be taken.
// At reset the entry valid bits clear at once: no clearing pass, the first
// request is taken the cycle after reset goes away. The result holds in o_rsp
// until taken; a further request is still worked and waits in its last state.
`default_nettype none
module shared_exclusive_lock_table #(
    parameter int ENTRIES          = 128,
    parameter int SHARED_PER_ENTRY = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sel_req_if.sink   i_req,
    sel_rsp_if.source o_rsp,
    sel_cfg_if.sink   i_cfg
);
    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(SHARED_PER_ENTRY + 1);
    localparam int LD = ENTRIES * SHARED_PER_ENTRY;
    localparam int LW = $clog2(LD);

    // header memory: key, exclusive holder, shared count
    logic [31:0]   m_key  [ENTRIES];
    logic [15:0]   m_excl [ENTRIES];
    logic [CW-1:0] m_cnt  [ENTRIES];
    logic [15:0]   m_list [LD];
    logic [ENTRIES-1:0] r_used;

    sel_pkg::t_state r_state, n_state;
    logic          r_ready;
    logic          r_func;
    logic [15:0]   r_who;
    logic [31:0]   r_fkey;
    logic [3:0]    r_mode;
    logic [EW:0]   r_e;        // entry index, one extra bit for end of scan
    logic [CW:0]   r_i;        // list index
    logic [CW-1:0] r_pos;      // found position, valid when r_hit
    logic          r_hit;
    logic          r_ovalid;
    logic [2:0]    r_status;
    logic [2:0]    r_rsp_status;
    logic          r_tables_ready;

    // registered memory read data
    logic [31:0]   r_rkey;
    logic [15:0]   r_rexcl;
    logic [CW-1:0] r_rcnt;
    logic [15:0]   r_rlist;

    // memory access controls (combinational)
    logic          hd_we;
    logic [15:0]   hd_excl_w;
    logic [CW-1:0] hd_cnt_w;
    logic          key_we;
    logic          ls_we;
    logic [LW-1:0] ls_waddr;
    logic [15:0]   ls_wdata;
    logic [EW-1:0] hd_raddr;
    logic [LW-1:0] ls_raddr;

    logic [EW-1:0] e_ix;
    logic [EW-1:0] prev_ix;
    assign e_ix = r_e[EW-1:0];
    assign prev_ix = EW'(r_e - 1'b1);

    function automatic logic [LW-1:0] laddr(input logic [EW-1:0] e,
                                            input logic [CW:0] i);
        logic [LW+CW:0] a;
        a = (LW+CW+1)'(e) * (LW+CW+1)'(SHARED_PER_ENTRY) + (LW+CW+1)'(i);
        return a[LW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (hd_we) begin
            m_excl[e_ix] <= hd_excl_w;
            m_cnt[e_ix]  <= hd_cnt_w;
        end
        if (key_we) m_key[e_ix] <= r_fkey;
        if (ls_we) m_list[ls_waddr] <= ls_wdata;
        r_rkey  <= m_key[hd_raddr];
        r_rexcl <= m_excl[hd_raddr];
        r_rcnt  <= m_cnt[hd_raddr];
        r_rlist <= m_list[ls_raddr];
    end

    // decoded request
    logic [3:0] mode_c;
    logic       mode_ok;
    assign mode_c  = i_req.operation & ~sel_pkg::OP_NONBLK;
    assign mode_ok = (mode_c == sel_pkg::OP_SHARED) || (mode_c == sel_pkg::OP_EXCL)
                     || (mode_c == sel_pkg::OP_UNLOCK);

    logic req_acc;
    logic cfg_acc;
    // a configuration word takes the idle slot ahead of a request
    assign i_req.ready = r_ready && !i_cfg.valid;
    assign i_cfg.ready = r_ready;
    assign req_acc = i_req.valid && i_req.ready;
    assign cfg_acc = i_cfg.valid && i_cfg.ready;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.status = r_rsp_status;

    logic [CW-1:0] cnt_eff;   // count as seen in S_LIST / S_APPLY
    logic          last_e;
    assign last_e = (r_e == (EW+1)'(ENTRIES - 1));

    logic          n_ready, n_ovalid, n_hit;
    logic [2:0]    n_status;
    logic [EW:0]   n_e;
    logic [CW:0]   n_i;
    logic [CW-1:0] n_pos;
    logic [ENTRIES-1:0] n_used;
    logic [15:0]   excl_now;
    logic          others;

    assign cnt_eff = r_rcnt;

    always_comb begin
        n_state = r_state;
        n_ready = r_ready;
        n_ovalid = r_ovalid;
        n_status = r_status;
        n_e = r_e;
        n_i = r_i;
        n_pos = r_pos;
        n_hit = r_hit;
        n_used = r_used;
        hd_we = 1'b0;
        hd_excl_w = r_rexcl;
        hd_cnt_w = r_rcnt;
        key_we = 1'b0;
        ls_we = 1'b0;
        ls_waddr = laddr(e_ix, r_i);
        ls_wdata = r_rlist;
        hd_raddr = e_ix;
        ls_raddr = laddr(e_ix, r_i);
        excl_now = r_rexcl;
        others = 1'b0;
        unique case (r_state)
            sel_pkg::S_IDLE: begin
                if (r_ovalid && o_rsp.ready) n_ovalid = 1'b0;
                if (req_acc) begin
                    n_ready = 1'b0;
                    n_e = '0;
                    n_hit = 1'b0;
                    n_status = sel_pkg::ST_OK;
                    if (i_req.func == sel_pkg::FUNC_RELEASE) begin
                        n_state = (r_tables_ready && i_req.owner_id != 16'd0)
                                  ? sel_pkg::S_REL : sel_pkg::S_DONE;
                    end else if (i_req.owner_id == 16'd0) begin
                        n_status = sel_pkg::ST_BADF;
                        n_state = sel_pkg::S_DONE;
                    end else if (!mode_ok || !r_tables_ready) begin
                        n_status = sel_pkg::ST_INVAL;
                        n_state = sel_pkg::S_DONE;
                    end else if (i_req.file_key == 32'd0) begin
                        n_state = sel_pkg::S_DONE;
                    end else if (mode_c == sel_pkg::OP_UNLOCK) begin
                        n_state = sel_pkg::S_REL;
                    end else begin
                        n_state = sel_pkg::S_FIND;
                    end
                end
            end
            sel_pkg::S_FIND: begin
                // r_rkey belongs to r_e-1 once r_hit marks a pending read
                if (r_hit && r_used[prev_ix] && r_rkey == r_fkey) begin
                    n_e = r_e - 1'b1;
                    n_hit = 1'b0;
                    n_state = sel_pkg::S_ENTRY;
                    hd_raddr = prev_ix;
                end else if (r_e == (EW+1)'(ENTRIES)) begin
                    n_e = '0;
                    n_hit = 1'b0;
                    n_state = sel_pkg::S_FREE;
                end else begin
                    n_hit = 1'b1;
                    n_e = r_e + 1'b1;
                end
            end
            sel_pkg::S_FREE: begin
                if (r_e == (EW+1)'(ENTRIES)) begin
                    n_status = sel_pkg::ST_FULL;
                    n_state = sel_pkg::S_DONE;
                end else if (!r_used[e_ix]) begin
                    n_used[e_ix] = 1'b1;
                    key_we = 1'b1;
                    hd_we = 1'b1;
                    hd_excl_w = '0;
                    hd_cnt_w = '0;
                    n_state = sel_pkg::S_ENTRY;
                end else begin
                    n_e = r_e + 1'b1;
                end
            end
            sel_pkg::S_ENTRY: begin
                // header read in flight (or just written); start list walk
                n_i = '0;
                n_hit = 1'b0;
                n_state = sel_pkg::S_LIST;
            end
            sel_pkg::S_LIST: begin
                // r_rlist holds slot r_i-1 when r_i > 0
                if (r_i != '0 && !r_hit && r_rlist == r_who
                        && (r_i - 1'b1) < (CW+1)'(cnt_eff)) begin
                    n_hit = 1'b1;
                    n_pos = CW'(r_i - 1'b1);
                end
                if (r_i >= (CW+1)'(cnt_eff) + 1'b1 || r_i > (CW+1)'(SHARED_PER_ENTRY)) begin
                    n_state = (r_func == sel_pkg::FUNC_RELEASE || r_mode == sel_pkg::OP_UNLOCK)
                              ? sel_pkg::S_RELW : sel_pkg::S_APPLY;
                    n_i = (CW+1)'(n_pos) + 1'b1;
                    ls_raddr = laddr(e_ix, (CW+1)'(n_pos) + 1'b1);
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            sel_pkg::S_APPLY: begin
                if (r_mode == sel_pkg::OP_SHARED) begin
                    if (r_rexcl != 16'd0 && r_rexcl != r_who) begin
                        n_status = sel_pkg::ST_AGAIN;
                        n_state = sel_pkg::S_DONE;
                    end else begin
                        if (r_rexcl == r_who) excl_now = 16'd0;
                        hd_we = 1'b1;
                        hd_excl_w = excl_now;
                        n_state = sel_pkg::S_DONE;
                        if (!r_hit) begin
                            if (r_rcnt >= CW'(SHARED_PER_ENTRY)) begin
                                n_status = sel_pkg::ST_FULL;
                            end else begin
                                ls_we = 1'b1;
                                ls_waddr = laddr(e_ix, (CW+1)'(r_rcnt));
                                ls_wdata = r_who;
                                hd_cnt_w = r_rcnt + 1'b1;
                            end
                        end
                    end
                end else begin
                    others = (r_rcnt - CW'(r_hit)) != '0;
                    if ((r_rexcl != 16'd0 && r_rexcl != r_who) || others) begin
                        n_status = sel_pkg::ST_AGAIN;
                        n_state = sel_pkg::S_DONE;
                    end else begin
                        hd_we = 1'b1;
                        hd_excl_w = r_who;
                        if (r_hit) begin
                            // sole shared holder: slot goes away
                            hd_cnt_w = r_rcnt - 1'b1;
                        end
                        n_state = sel_pkg::S_DONE;
                    end
                end
            end
            sel_pkg::S_REL: begin
                if (r_e == (EW+1)'(ENTRIES)) begin
                    n_state = sel_pkg::S_DONE;
                end else if (r_used[e_ix]) begin
                    n_state = sel_pkg::S_ENTRY;
                end else begin
                    n_e = r_e + 1'b1;
                end
            end
            sel_pkg::S_RELW: begin
                // shift tail down over the removed slot, one slot per pass through S_SHIFT;
                // r_rlist holds slot r_i
                if (r_hit && r_i < (CW+1)'(r_rcnt)) begin
                    ls_we = 1'b1;
                    ls_waddr = laddr(e_ix, r_i - 1'b1);
                    ls_wdata = r_rlist;
                    n_i = r_i + 1'b1;
                    ls_raddr = laddr(e_ix, r_i + 1'b1);
                    n_state = sel_pkg::S_SHIFT;
                end else begin
                    excl_now = (r_rexcl == r_who) ? 16'd0 : r_rexcl;
                    hd_we = 1'b1;
                    hd_excl_w = excl_now;
                    hd_cnt_w = r_rcnt - CW'(r_hit);
                    if (excl_now == 16'd0 && hd_cnt_w == '0) n_used[e_ix] = 1'b0;
                    if (last_e) begin
                        n_state = sel_pkg::S_DONE;
                    end else begin
                        n_e = r_e + 1'b1;
                        n_state = sel_pkg::S_REL;
                    end
                end
            end
            sel_pkg::S_SHIFT: begin
                // read latency gap before the next shift step
                ls_raddr = laddr(e_ix, r_i);
                n_state = sel_pkg::S_RELW;
            end
            sel_pkg::S_DONE: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid = 1'b1;
                    n_ready = 1'b1;
                    n_state = sel_pkg::S_IDLE;
                end
            end
            default: n_state = sel_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sel_pkg::S_IDLE;
            r_ready <= 1'b1;
            r_ovalid <= 1'b0;
            r_used <= '0;
            r_hit <= 1'b0;
            r_tables_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
            r_ovalid <= (r_state == sel_pkg::S_DONE) ? n_ovalid
                        : ((r_ovalid && o_rsp.ready) ? 1'b0 : r_ovalid);
            r_used <= n_used;
            r_hit <= n_hit;
            if (cfg_acc) r_tables_ready <= i_cfg.tables_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e <= n_e;
        r_i <= n_i;
        r_pos <= n_pos;
        r_status <= n_status;
        // load the result word only when the previous one has gone
        if (r_state == sel_pkg::S_DONE && (!r_ovalid || o_rsp.ready))
            r_rsp_status <= r_status;
        if (r_state == sel_pkg::S_IDLE && req_acc) begin
            r_func <= i_req.func;
            r_who <= i_req.owner_id;
            r_fkey <= i_req.file_key;
            r_mode <= mode_c;
        end
    end

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> r_state == sel_pkg::S_IDLE)
        else $error("ready outside idle");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sel_pkg::S_DONE && !r_ovalid) |=> r_ovalid)
        else $error("result not raised");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !r_ready)
        else $error("second request taken");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_rsp_status <= sel_pkg::ST_FULL)
        else $error("status out of range");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> (o_rsp.valid && $stable(o_rsp.status)))
        else $error("result word changed while waiting");
`endif
endmodule
`default_nettype wire
